>>> hw/rtl/latest_per_type_mailbox_rr_unit_assert.svh
// Assertion macros used by the checker file of the mailbox block.
// Depends on nothing; included by bare file name.
`ifndef LATEST_PER_TYPE_MAILBOX_RR_UNIT_ASSERT_SVH
`define LATEST_PER_TYPE_MAILBOX_RR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTMB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltmb: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltmb: assertion failed");

`endif

>>> hw/rtl/ltmb_pkg.sv
// Shared constants, codes and the result type of the latest-per-type mailbox.
// No dependencies.
`default_nettype none

package ltmb_pkg;

    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_TYPE_BITS     = 8;
    localparam int DEF_PAYLOAD_BYTES = 8;

    // Fixed port widths
    localparam int TYPE_PORT_BITS    = 8;
    localparam int LEN_BITS          = 4;
    localparam int PAYLOAD_PORT_BITS = 64;

    // Item mode
    localparam logic MODE_POST = 1'b0;

    // Result status codes
    localparam logic [1:0] STATUS_POSTED  = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_FETCHED = 2'd2;
    localparam logic [1:0] STATUS_NO_MSG  = 2'd3;

    typedef struct packed {
        logic [1:0]                   status;
        logic [TYPE_PORT_BITS-1:0]    out_type;
        logic [LEN_BITS-1:0]          out_length;
        logic [PAYLOAD_PORT_BITS-1:0] out_payload;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ltmb_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Depends on ltmb_pkg for default sizes.
`default_nettype none

module ltmb_ram #(
    parameter int DEPTH = ltmb_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = ltmb_pkg::DEF_TYPE_BITS + ltmb_pkg::LEN_BITS
                          + 8 * ltmb_pkg::DEF_PAYLOAD_BYTES
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ltmb_out_reg.sv
// Output register of the mailbox: holds one result item until the receiver takes it.
// Depends on ltmb_pkg for result_t.
`default_nettype none

module ltmb_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire ltmb_pkg::result_t din,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output ltmb_pkg::result_t     dout,
    output logic                  can_load
);

    logic              valid_reg;
    logic              valid_next;
    ltmb_pkg::result_t data_reg;

    // free when empty or being taken this cycle
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/latest_per_type_mailbox_rr_unit.sv
// Latest-per-type mailbox with round-robin fetch: top level.
// Channels: input items (mode, msg_type, msg_length, payload) on in_valid/in_stall,
// result items (status, out_type, out_length, out_payload) on out_valid/out_stall.
// Every item gives exactly one result item. A post keeps one message per type;
// a fetch returns the next valid message round robin from the read pointer.
// The table lives in one synchronous RAM (type, length, payload per entry) read
// and written by a sequencer, one entry per cycle; valid marks are flip-flops.
// Steps per item, from accept to result register:
//   post, in-place or new type: lookup
//   post, length change:        lookup, then shift
//   fetch:                      valid scan, then RAM read
// The result shows on the output ports right after the edge that loads it.
// in_stall is low only while the sequencer is idle, so the next item is taken
// at the earliest in the cycle after the result is loaded; it can be taken while
// a finished result still waits in the output register.
// Reset clears the valid marks, the entry count and the read pointer; the table
// RAM needs no clearing pass, so the block is ready right after reset.
// While out_stall is high the result holds; a later item is worked on but its
// result waits for the output register to free up.
// Depends on ltmb_pkg, ltmb_ram and ltmb_out_reg.
`default_nettype none

module latest_per_type_mailbox_rr_unit #(
    parameter int TABLE_DEPTH   = ltmb_pkg::DEF_TABLE_DEPTH,
    parameter int TYPE_BITS     = ltmb_pkg::DEF_TYPE_BITS,
    parameter int PAYLOAD_BYTES = ltmb_pkg::DEF_PAYLOAD_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  msg_type,
    input  wire logic [3:0]  msg_length,
    input  wire logic [63:0] payload,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       out_type,
    output logic [3:0]       out_length,
    output logic [63:0]      out_payload
);

    localparam int IW = $clog2(TABLE_DEPTH);          // entry index
    localparam int CW = $clog2(TABLE_DEPTH + 1);      // count / pointer
    // only the low port bits of the type ever reach the table
    localparam int TW = (TYPE_BITS < ltmb_pkg::TYPE_PORT_BITS) ?
                        TYPE_BITS : ltmb_pkg::TYPE_PORT_BITS;
    localparam int PW = 8 * PAYLOAD_BYTES;
    localparam int LW = ltmb_pkg::LEN_BITS;
    localparam int WW = TW + LW + PW;                 // RAM word: {type, length, data}

    localparam logic [LW-1:0] MAX_LEN  = LW'(PAYLOAD_BYTES);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PSCAN = 3'd1;   // post: type lookup
    localparam logic [2:0] ST_SHIFT = 3'd2;   // post: remove entry, shift down
    localparam logic [2:0] ST_FSCAN = 3'd3;   // fetch: round-robin valid scan
    localparam logic [2:0] ST_FREAD = 3'd4;   // fetch: RAM read returns
    localparam logic [2:0] ST_DONE  = 3'd5;   // result waits for output register

    // control state
    logic [2:0]             state_reg,  state_next;
    logic [CW-1:0]          idx_reg,    idx_next;     // next RAM/valid index to visit
    logic [CW-1:0]          steps_reg,  steps_next;   // fetch entries examined
    logic                   pend_reg,   pend_next;    // RAM read in flight
    logic [CW-1:0]          cnt_reg,    cnt_next;
    logic [CW-1:0]          rp_reg,     rp_next;
    logic [TABLE_DEPTH-1:0] valid_reg,  valid_next;

    // item and result payload
    logic [IW-1:0]          pend_idx_reg, pend_idx_next;
    logic [TW-1:0]          type_reg,     type_next;
    logic [LW-1:0]          len_reg,      len_next;
    logic [PW-1:0]          data_reg,     data_next;
    ltmb_pkg::result_t      res_reg,      res_next;

    // RAM port signals
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;
    logic [TW-1:0] rd_type;
    logic [LW-1:0] rd_len;
    logic [PW-1:0] rd_data;

    // input conditioning
    logic [LW-1:0] len_in;
    logic [PW-1:0] data_in;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_wrap;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] sh_dst;

    logic              out_load;
    logic              out_ready;
    ltmb_pkg::result_t out_res;

    assign rd_type = ram_rdata[WW-1 -: TW];
    assign rd_len  = ram_rdata[PW + LW - 1 -: LW];
    assign rd_data = ram_rdata[PW-1:0];

    // saturate length, zero the bytes beyond it
    always_comb
    begin
        len_in = (msg_length > MAX_LEN) ? MAX_LEN : msg_length;
        for (int b = 0; b < PAYLOAD_BYTES; b++)
        begin
            data_in[8*b +: 8] = (len_in > LW'(b)) ? payload[8*b +: 8] : 8'h00;
        end
    end

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_wrap = (idx_inc >= cnt_reg) ? '0 : idx_inc;
    assign cnt_m1   = cnt_reg - CW'(1);
    assign sh_dst   = pend_idx_reg - IW'(1);

    assign in_stall = (state_reg != ST_IDLE);

    // In-place and shift writes are sequenced so that they never target the entry
    // being read in the same cycle: lookup writes the compared entry while reading
    // the next, the shift writes entry j while reading j + 2.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        steps_next    = steps_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cnt_next      = cnt_reg;
        rp_next       = rp_reg;
        valid_next    = valid_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        data_next     = data_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = {type_reg, len_reg, data_reg};
        ram_raddr     = idx_reg[IW-1:0];
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    type_next  = msg_type[TW-1:0];
                    len_next   = len_in;
                    data_next  = data_in;
                    steps_next = '0;
                    if (mode == ltmb_pkg::MODE_POST)
                    begin
                        idx_next   = '0;
                        state_next = ST_PSCAN;
                    end
                    else
                    begin
                        // pointer at or past the count restarts at entry zero
                        idx_next   = (rp_reg >= cnt_reg) ? '0 : rp_reg;
                        state_next = ST_FSCAN;
                    end
                end
            end

            ST_PSCAN:
            begin
                if (pend_reg && (rd_type == type_reg))
                begin
                    if (rd_len == len_reg)
                    begin
                        // same type and length: overwrite in place
                        ram_we                   = 1'b1;
                        ram_waddr                = pend_idx_reg;
                        valid_next[pend_idx_reg] = 1'b1;
                        res_next                 = '0;
                        res_next.status          = ltmb_pkg::STATUS_POSTED;
                        state_next               = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = CW'(pend_idx_reg) + CW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (idx_reg < cnt_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                    idx_next      = idx_inc;
                end
                else if (!pend_reg)
                begin
                    res_next = '0;
                    if (cnt_reg == FULL_CNT)
                    begin
                        res_next.status = ltmb_pkg::STATUS_DROPPED;
                    end
                    else
                    begin
                        // new type: append
                        ram_we                       = 1'b1;
                        ram_waddr                    = cnt_reg[IW-1:0];
                        valid_next[cnt_reg[IW-1:0]]  = 1'b1;
                        cnt_next                     = cnt_reg + CW'(1);
                        res_next.status              = ltmb_pkg::STATUS_POSTED;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = sh_dst;
                    ram_wdata          = ram_rdata;
                    valid_next[sh_dst] = valid_reg[pend_idx_reg];
                end
                if (idx_reg < cnt_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                    idx_next      = idx_inc;
                end
                else if (!pend_reg)
                begin
                    // re-post at the tail
                    ram_we                     = 1'b1;
                    ram_waddr                  = cnt_m1[IW-1:0];
                    valid_next[cnt_m1[IW-1:0]] = 1'b1;
                    res_next                   = '0;
                    res_next.status            = ltmb_pkg::STATUS_POSTED;
                    state_next                 = ST_DONE;
                end
            end

            ST_FSCAN:
            begin
                if (steps_reg < cnt_reg)
                begin
                    if (valid_reg[idx_reg[IW-1:0]])
                    begin
                        valid_next[idx_reg[IW-1:0]] = 1'b0;
                        rp_next                     = idx_wrap;
                        state_next                  = ST_FREAD;
                    end
                    else
                    begin
                        idx_next   = idx_wrap;
                        steps_next = steps_reg + CW'(1);
                    end
                end
                else
                begin
                    // nothing valid
                    res_next        = '0;
                    res_next.status = ltmb_pkg::STATUS_NO_MSG;
                    rp_next         = cnt_reg;
                    state_next      = ST_DONE;
                end
            end

            ST_FREAD:
            begin
                res_next.status      = ltmb_pkg::STATUS_FETCHED;
                res_next.out_type    = ltmb_pkg::TYPE_PORT_BITS'(rd_type);
                res_next.out_length  = rd_len;
                res_next.out_payload = ltmb_pkg::PAYLOAD_PORT_BITS'(rd_data);
                state_next           = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            steps_reg <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            rp_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            steps_reg <= steps_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            rp_reg    <= rp_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        type_reg     <= type_next;
        len_reg      <= len_next;
        data_reg     <= data_next;
        res_reg      <= res_next;
    end

    ltmb_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ltmb_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .din       (res_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .dout      (out_res),
        .can_load  (out_ready)
    );

    assign status      = out_res.status;
    assign out_type    = out_res.out_type;
    assign out_length  = out_res.out_length;
    assign out_payload = out_res.out_payload;

endmodule

`default_nettype wire

>>> hw/rtl/ltmb_checker.sv
// Port-level checker for the mailbox top level, attached by bind.
// Depends on ltmb_pkg and latest_per_type_mailbox_rr_unit_assert.svh.
`default_nettype none

`include "latest_per_type_mailbox_rr_unit_assert.svh"

module ltmb_checker #(
    parameter int PAYLOAD_BYTES = ltmb_pkg::DEF_PAYLOAD_BYTES
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [7:0]  out_type,
    input wire logic [3:0]  out_length,
    input wire logic [63:0] out_payload
);

    // an accepted item keeps the block busy in the cycle after it is taken
    `LTMB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // only a fetched message carries type, length and payload
    `LTMB_ASSERT_IMPLIES(a_empty_fields, clk, rst_n, out_valid && (status != ltmb_pkg::STATUS_FETCHED), (out_type == 8'd0) && (out_length == 4'd0) && (out_payload == 64'd0))

    // stored lengths never exceed the payload size
    `LTMB_ASSERT_IMPLIES(a_len_bound, clk, rst_n, out_valid, out_length <= 4'(PAYLOAD_BYTES))

    // a stalled result holds
    `LTMB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(out_payload))

endmodule

bind latest_per_type_mailbox_rr_unit ltmb_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_ltmb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_type    (out_type),
    .out_length  (out_length),
    .out_payload (out_payload)
);

`default_nettype wire
